// ----- rtl/clf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_pkg
// Shared types and constants of the content length framer: result word
// layout, result kinds, byte codes and the header name that is matched.
// ----------------------------------------------------------------------------
package clf_pkg;

	// result kinds
	localparam logic [1:0] KIND_BODY  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// byte codes
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// maximum body length register
	localparam int unsigned MAX_LEN_W = 24;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 24'd1048576;

	// header name to match
	localparam logic [3:0] NAME_LEN = 4'd14;

	// one result word
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] body_byte;
		logic       last;
	} res_t;

	// character of the matched header name at a given position
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/content_length_framer_unit.sv -----
`timescale 1ns / 1ps
// A word accepted is registered at the input stage and its result, if any, is
// registered in the result register when that register is free or drains.
// Throughput: one input word per cycle unless a stalled result holds stage 1;
// the state update for a byte fits between the input register and the result register.
// Reset: arst_n clears both stages, the parser state and sets max_len_q to
// 1048576; no clearing pass is needed.
// ----------------------------------------------------------------------------
// content_length_framer_unit
// Splits a framed byte stream into header and body; emits body bytes, empty
// message and length error results.
// ----------------------------------------------------------------------------
module content_length_framer_unit
	import clf_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [MAX_LEN_W-1:0] cfg_wdata,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [7:0]           data_byte,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [1:0]           kind,
	output logic [7:0]           body_byte,
	output logic                 last
);

	logic [MAX_LEN_W-1:0] max_len_q;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 advance;
	logic                 step;
	logic                 res_valid;
	res_t                 res;
	logic                 out_valid_q;
	res_t                 out_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	// handshake: stage 1 moves on when the output register is free or drains
	assign advance    = !out_valid_q || !result_stall;
	assign step       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// header and body parser
	clf_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = out_q.kind;
	assign body_byte    = out_q.body_byte;
	assign last         = out_q.last;

`ifndef NO_ASSERTIONS
	// the input only stalls behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (result_valid && result_stall))
		else $error("input stalled without a stalled result");

	// empty and error results always close a message
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind != KIND_BODY) |-> (last && body_byte == 8'h00))
		else $error("non-body result without last or with data");

	// only defined kinds appear
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (kind == KIND_BODY || kind == KIND_EMPTY || kind == KIND_ERROR))
		else $error("undefined result kind");

	// a word held in stage 1 under stall is not lost
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |=> valid_s1)
		else $error("stage 1 word dropped under stall");
`endif

endmodule

// ----- rtl/clf_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clf_parser
// Header and body state machine. One byte is taken per step; the state is
// updated at that edge and the result word for the byte is given alongside.
// ----------------------------------------------------------------------------
module clf_parser
	import clf_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic [MAX_LEN_W-1:0] max_len,
	output logic                 res_valid,
	output res_t                 res
);

	localparam int unsigned CMP_W = (LENGTH_BITS > MAX_LEN_W) ? LENGTH_BITS : MAX_LEN_W;
	localparam int unsigned EXT_W = LENGTH_BITS + 4;

	typedef enum logic [2:0] {
		PH_LINE_START,
		PH_BLANK_CR,
		PH_NAME,
		PH_VALUE,
		PH_IGNORE,
		PH_SKIP,
		PH_BODY
	} phase_t;

	phase_t                 phase_q, n_phase;
	logic [3:0]             cnt_q, n_cnt;
	logic                   match_q, n_match;
	logic                   dig_q, n_dig;
	logic [LENGTH_BITS-1:0] acc_q, n_acc;
	logic [LENGTH_BITS-1:0] rem_q, n_rem;

	logic                   is_eol;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [EXT_W-1:0]       acc_ext;
	logic [EXT_W-1:0]       acc_next_ext;
	logic [LENGTH_BITS-1:0] acc_sat;
	logic                   too_long;
	logic [LENGTH_BITS-1:0] rem_dec;
	logic                   do_name;
	logic [3:0]             name_cnt;
	logic                   name_ok;

	// byte classes
	assign is_eol   = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
	assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
	assign digit    = 4'(data_byte - CHAR_ZERO);

	// decimal accumulate, times ten by shift and add, saturating
	assign acc_ext      = EXT_W'(acc_q);
	assign acc_next_ext = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(digit);
	assign acc_sat      = (|acc_next_ext[EXT_W-1:LENGTH_BITS]) ? '1
	                      : acc_next_ext[LENGTH_BITS-1:0];

	// length limit check and body countdown
	assign too_long = CMP_W'(acc_q) > CMP_W'(max_len);
	assign rem_dec  = rem_q - LENGTH_BITS'(1);

	// next state and result
	always_comb begin
		n_phase   = phase_q;
		n_cnt     = cnt_q;
		n_match   = match_q;
		n_dig     = dig_q;
		n_acc     = acc_q;
		n_rem     = rem_q;
		res_valid = 1'b0;
		res       = '0;
		do_name   = 1'b0;
		name_cnt  = cnt_q;
		name_ok   = match_q;

		case (phase_q)
			PH_LINE_START: begin
				name_cnt = 4'd0;
				name_ok  = 1'b1;
				n_cnt    = 4'd0;
				n_match  = 1'b1;
				if (data_byte == CHAR_CR) begin
					n_phase = PH_BLANK_CR;
				end else begin
					do_name = 1'b1;
				end
			end
			PH_BLANK_CR: begin
				if (data_byte == CHAR_LF) begin
					res_valid = 1'b1;
					res.last  = 1'b1;
					if (acc_q == '0) begin
						res.kind = KIND_EMPTY;
					end else if (too_long) begin
						res.kind = KIND_ERROR;
					end else begin
						res_valid = 1'b0;
						res.last  = 1'b0;
						n_rem     = acc_q;
						n_phase   = PH_BODY;
					end
					// end of message without body
					if (res_valid) begin
						n_phase = PH_LINE_START;
						n_cnt   = 4'd0;
						n_match = 1'b1;
						n_dig   = 1'b0;
						n_acc   = '0;
						n_rem   = '0;
					end
				end else begin
					// lone cr starts a name that cannot match
					name_ok = 1'b0;
					n_match = 1'b0;
					do_name = 1'b1;
				end
			end
			PH_NAME: begin
				do_name = 1'b1;
			end
			PH_VALUE: begin
				if (is_eol) begin
					n_phase = PH_SKIP;
				end else if (is_digit) begin
					n_acc = acc_sat;
					n_dig = 1'b1;
				end else if (!(data_byte == CHAR_SPACE && !dig_q)) begin
					n_phase = PH_IGNORE;
				end
			end
			PH_IGNORE: begin
				if (is_eol) begin
					n_phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				n_phase = PH_LINE_START;
			end
			PH_BODY: begin
				n_rem          = rem_dec;
				res_valid      = 1'b1;
				res.kind       = KIND_BODY;
				res.body_byte  = data_byte;
				if (rem_dec == '0) begin
					res.last = 1'b1;
					n_phase  = PH_LINE_START;
					n_cnt    = 4'd0;
					n_match  = 1'b1;
					n_dig    = 1'b0;
					n_acc    = '0;
				end
			end
			default: begin
				n_phase = PH_LINE_START;
				n_cnt   = 4'd0;
				n_match = 1'b1;
				n_dig   = 1'b0;
				n_acc   = '0;
				n_rem   = '0;
			end
		endcase

		// header name byte
		if (do_name) begin
			if (is_eol) begin
				n_phase = PH_SKIP;
			end else if (data_byte == CHAR_COLON) begin
				if (name_ok && name_cnt == NAME_LEN) begin
					n_acc   = '0;
					n_dig   = 1'b0;
					n_phase = PH_VALUE;
				end else begin
					n_phase = PH_IGNORE;
				end
			end else begin
				if (name_ok && name_cnt < NAME_LEN && data_byte == key_char(name_cnt)) begin
					n_cnt = name_cnt + 4'd1;
				end else begin
					n_match = 1'b0;
				end
				n_phase = PH_NAME;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LINE_START;
			cnt_q   <= 4'd0;
			match_q <= 1'b1;
			dig_q   <= 1'b0;
			acc_q   <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= n_phase;
			cnt_q   <= n_cnt;
			match_q <= n_match;
			dig_q   <= n_dig;
			acc_q   <= n_acc;
			rem_q   <= n_rem;
		end
	end

endmodule
